@@ sv/assert_macros.svh @@
// Assertion macros shared by the lexer's checking code.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property checked at every rising edge of clk outside reset.
`define TLEX_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// An implication checked in the same cycle.
`define TLEX_IMPLY(lbl, ante, cons, msg) \
  `TLEX_CHECK(lbl, (ante) |-> (cons), msg)

`endif

@@ sv/tlex_pkg.sv @@
// Types, codes and character constants shared across the token lexer.
package tlex_pkg;

  localparam int WORD_CHARS_DEF = 8;
  localparam int COORD_BITS_DEF = 16;

  // Result slots that one source byte can fill.
  localparam int SLOTS = 4;
  localparam int SLOT_IDX_BITS = $clog2(SLOTS);

  // Token kinds.
  localparam logic [2:0] KIND_WORD      = 3'd0;
  localparam logic [2:0] KIND_INT       = 3'd1;
  localparam logic [2:0] KIND_OPEN      = 3'd2;
  localparam logic [2:0] KIND_CLOSE     = 3'd3;
  localparam logic [2:0] KIND_COMMA     = 3'd4;
  localparam logic [2:0] KIND_EQUALS    = 3'd5;
  localparam logic [2:0] KIND_EOF       = 3'd6;
  localparam logic [2:0] KIND_PAREN_ERR = 3'd7;

  // Paren error kinds.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_CLOSER = 2'd1;
  localparam logic [1:0] ERR_OPENER = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7a;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_OPEN    = 8'h28;
  localparam logic [7:0] CH_CLOSE   = 8'h29;
  localparam logic [7:0] CH_EQUALS  = 8'h3d;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;

  // Integer saturation value.
  localparam logic [30:0] INT_SAT = 31'h7fffffff;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_text;
  } item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [63:0] word_text;
    logic [7:0]  word_length;
    logic [30:0] integer_value;
    logic        integer_overflow;
    logic [1:0]  error_kind;
    logic [15:0] line_number;
    logic [15:0] column_number;
    logic        last_result;
  } result_t;

  // Results of one byte, in emission order, with a mask of those present.
  typedef struct packed {
    logic [SLOTS-1:0]          mask;
    result_t [SLOTS-1:0]       slot;
  } bundle_t;

endpackage

@@ sv/token_lexer_with_paren_check.sv @@
// A byte is held in the input register and its results in the result register before they go out.
// One byte per cycle while each byte yields at most one result and the output does not stall;
// a byte that yields several results (at most four) holds the result register until its last is taken.
// The input register takes the next byte while a result waits to be taken.
// Reset (rst, synchronous): no run open, line 1 column 1, paren counters cleared,
// and no result pending. The end of each text returns the run, position and paren counters to these values.
`include "assert_macros.svh"

module token_lexer_with_paren_check #(
  parameter int WORD_CHARS = tlex_pkg::WORD_CHARS_DEF,
  parameter int COORD_BITS = tlex_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  tlex_pkg::item_t   src_beat,
  output logic              tok_valid,
  input  logic              tok_stall,
  output tlex_pkg::result_t tok_beat
);

  logic              slot_free;
  logic              bundle_load;
  tlex_pkg::bundle_t bundle;

  // Byte processing and lexer state.
  tlex_core #(
    .WORD_CHARS(WORD_CHARS),
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_stall   (src_stall),
    .src_beat    (src_beat),
    .slot_free   (slot_free),
    .bundle_load (bundle_load),
    .bundle      (bundle)
  );

  // Result beats.
  tlex_out_seq u_out (
    .clk         (clk),
    .rst         (rst),
    .bundle_load (bundle_load),
    .bundle      (bundle),
    .slot_free   (slot_free),
    .tok_valid   (tok_valid),
    .tok_stall   (tok_stall),
    .tok_beat    (tok_beat)
  );

  // The input side only waits behind a pending result.
  `TLEX_IMPLY(a_stall_needs_result, src_stall, tok_valid, "input stalled with no result pending")
  // A paren error is always the final beat of its byte.
  `TLEX_IMPLY(a_err_is_last, tok_valid && tok_beat.token_kind == tlex_pkg::KIND_PAREN_ERR, tok_beat.last_result, "paren error not last")
  // Error kind is set exactly on paren error beats.
  `TLEX_IMPLY(a_err_kind_match, tok_valid, (tok_beat.token_kind == tlex_pkg::KIND_PAREN_ERR) == (tok_beat.error_kind != tlex_pkg::ERR_NONE), "error kind mismatch")

endmodule

@@ sv/tlex_core.sv @@
// Input register, lexer state and the single-pass token logic for one byte.
module tlex_core #(
  parameter int WORD_CHARS = tlex_pkg::WORD_CHARS_DEF,
  parameter int COORD_BITS = tlex_pkg::COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  tlex_pkg::item_t   src_beat,
  input  logic              slot_free,
  output logic              bundle_load,
  output tlex_pkg::bundle_t bundle
);

  localparam int CHAR_BITS = WORD_CHARS * 8;

  typedef enum logic [1:0] {RUN_NONE, RUN_WORD, RUN_NUM} run_t;

  typedef logic [COORD_BITS-1:0] coord_t;

  // Input register.
  logic            item_valid;
  tlex_pkg::item_t item;

  // Lexer state.
  run_t                 run_mode;
  logic [CHAR_BITS-1:0] word_buffer;
  logic [7:0]           word_count;
  logic [30:0]          num_acc;
  logic                 num_sat;
  coord_t               start_line, start_col;
  coord_t               cur_line, cur_col;
  logic [16:0]          balance;
  logic [15:0]          open_depth;
  logic                 under_seen;
  coord_t               under_line, under_col;
  coord_t               outer_line, outer_col;

  // Values after this byte.
  run_t                 run_mode_next;
  logic [CHAR_BITS-1:0] word_buffer_next;
  logic [7:0]           word_count_next;
  logic [30:0]          num_acc_next;
  logic                 num_sat_next;
  coord_t               start_line_next, start_col_next;
  coord_t               cur_line_next, cur_col_next;
  logic [16:0]          balance_next;
  logic [15:0]          open_depth_next;
  logic                 under_seen_next;
  coord_t               under_line_next, under_col_next;
  coord_t               outer_line_next, outer_col_next;

  logic [7:0]           b;
  logic                 is_alpha, is_digit;
  logic                 keep_word, keep_num, pre_close, end_close;
  logic [CHAR_BITS-1:0] buf_base;
  logic [7:0]           cnt_base;
  logic [30:0]          acc_base;
  logic                 sat_base;
  logic [34:0]          prod;
  logic                 tok_hit;
  logic [2:0]           tok_kind;
  logic                 accept, advance;

  function automatic coord_t sat_inc(input coord_t v);
    return (v == '1) ? v : v + COORD_BITS'(1);
  endfunction

  function automatic tlex_pkg::result_t marker(input logic [2:0] kind,
                                               input coord_t line, input coord_t col);
    tlex_pkg::result_t r;
    r               = '0;
    r.token_kind    = kind;
    r.line_number   = 16'(line);
    r.column_number = 16'(col);
    return r;
  endfunction

  function automatic tlex_pkg::result_t run_result(input run_t mode,
      input logic [CHAR_BITS-1:0] text, input logic [7:0] len,
      input logic [30:0] val, input logic ovf, input coord_t line, input coord_t col);
    tlex_pkg::result_t r;
    if (mode == RUN_WORD) begin
      r             = marker(tlex_pkg::KIND_WORD, line, col);
      r.word_text   = 64'(text);
      r.word_length = len;
    end else begin
      r                  = marker(tlex_pkg::KIND_INT, line, col);
      r.integer_value    = val;
      r.integer_overflow = ovf;
    end
    return r;
  endfunction

  // Handshake: the input register refills when it is empty or moving on.
  assign advance     = item_valid && slot_free;
  assign src_stall   = item_valid && !advance;
  assign accept      = src_valid && !src_stall;
  assign bundle_load = advance;
  assign b           = item.source_byte;

  // Byte classification and the run that follows this byte.
  always_comb begin
    is_alpha  = (b >= tlex_pkg::CH_LOWER_A && b <= tlex_pkg::CH_LOWER_Z) ||
                (b >= tlex_pkg::CH_UPPER_A && b <= tlex_pkg::CH_UPPER_Z);
    is_digit  = b >= tlex_pkg::CH_ZERO && b <= tlex_pkg::CH_NINE;
    keep_word = is_alpha && run_mode == RUN_WORD;
    keep_num  = is_digit && run_mode == RUN_NUM;
    pre_close = run_mode != RUN_NONE && !keep_word && !keep_num;

    run_mode_next = is_alpha ? RUN_WORD : (is_digit ? RUN_NUM : RUN_NONE);
    if ((is_alpha || is_digit) && !keep_word && !keep_num) begin
      start_line_next = cur_line;
      start_col_next  = cur_col;
    end else begin
      start_line_next = start_line;
      start_col_next  = start_col;
    end

    // Word characters: store into the lane picked by the count.
    buf_base = keep_word ? word_buffer : '0;
    cnt_base = keep_word ? word_count : 8'd0;
    word_buffer_next = '0;
    word_count_next  = 8'd0;
    if (is_alpha) begin
      word_buffer_next = buf_base;
      for (int i = 0; i < WORD_CHARS; i++) begin
        if (cnt_base == 8'(i)) begin
          word_buffer_next[i*8 +: 8] = b;
        end
      end
      word_count_next = (cnt_base == 8'hff) ? cnt_base : cnt_base + 8'd1;
    end

    // Decimal accumulation with saturation.
    acc_base = keep_num ? num_acc : 31'd0;
    sat_base = keep_num && num_sat;
    prod     = 35'(acc_base) * 35'd10 + 35'(b[3:0]);
    num_acc_next = 31'd0;
    num_sat_next = 1'b0;
    if (is_digit) begin
      if (prod > 35'(tlex_pkg::INT_SAT)) begin
        num_acc_next = tlex_pkg::INT_SAT;
        num_sat_next = 1'b1;
      end else begin
        num_acc_next = prod[30:0];
        num_sat_next = sat_base;
      end
    end
  end

  // Single-character tokens, paren tracking and position.
  always_comb begin
    tok_hit         = 1'b1;
    tok_kind        = tlex_pkg::KIND_COMMA;
    balance_next    = balance;
    open_depth_next = open_depth;
    under_seen_next = under_seen;
    under_line_next = under_line;
    under_col_next  = under_col;
    outer_line_next = outer_line;
    outer_col_next  = outer_col;
    case (b)
      tlex_pkg::CH_OPEN: begin
        tok_kind = tlex_pkg::KIND_OPEN;
        if (open_depth == 16'd0) begin
          outer_line_next = cur_line;
          outer_col_next  = cur_col;
        end
        if (open_depth != 16'hffff) begin
          open_depth_next = open_depth + 16'd1;
        end
        balance_next = balance + 17'd1;
      end
      tlex_pkg::CH_CLOSE: begin
        tok_kind = tlex_pkg::KIND_CLOSE;
        if (open_depth == 16'd0) begin
          if (!under_seen) begin
            under_seen_next = 1'b1;
            under_line_next = cur_line;
            under_col_next  = cur_col;
          end
        end else begin
          open_depth_next = open_depth - 16'd1;
        end
        balance_next = balance - 17'd1;
      end
      tlex_pkg::CH_COMMA:  tok_kind = tlex_pkg::KIND_COMMA;
      tlex_pkg::CH_EQUALS: tok_kind = tlex_pkg::KIND_EQUALS;
      default:             tok_hit  = 1'b0;
    endcase

    if (b == tlex_pkg::CH_NEWLINE) begin
      cur_line_next = sat_inc(cur_line);
      cur_col_next  = COORD_BITS'(1);
    end else begin
      cur_line_next = cur_line;
      cur_col_next  = sat_inc(cur_col);
    end
  end

  // Result slots in emission order.
  always_comb begin
    end_close = item.end_of_text && run_mode_next != RUN_NONE;
    bundle.slot[0] = run_result(run_mode, word_buffer, word_count, num_acc, num_sat,
                                start_line, start_col);
    if (end_close) begin
      bundle.slot[1] = run_result(run_mode_next, word_buffer_next, word_count_next,
                                  num_acc_next, num_sat_next, start_line_next,
                                  start_col_next);
    end else begin
      bundle.slot[1] = marker(tok_kind, cur_line, cur_col);
    end
    bundle.slot[2] = marker(tlex_pkg::KIND_EOF, cur_line_next, cur_col_next);
    if (under_seen_next) begin
      bundle.slot[3] = marker(tlex_pkg::KIND_PAREN_ERR, under_line_next, under_col_next);
      bundle.slot[3].error_kind = tlex_pkg::ERR_CLOSER;
    end else begin
      bundle.slot[3] = marker(tlex_pkg::KIND_PAREN_ERR, outer_line_next, outer_col_next);
      bundle.slot[3].error_kind = tlex_pkg::ERR_OPENER;
    end
    bundle.mask = {item.end_of_text && balance_next != 17'd0,
                   item.end_of_text,
                   end_close || tok_hit,
                   pre_close};
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
    if (accept) begin
      item <= src_beat;
    end
  end

  // Lexer state; the end of a text returns it to the reset values.
  always_ff @(posedge clk) begin
    if (rst || (advance && item.end_of_text)) begin
      run_mode    <= RUN_NONE;
      word_buffer <= '0;
      word_count  <= 8'd0;
      num_acc     <= 31'd0;
      num_sat     <= 1'b0;
      start_line  <= COORD_BITS'(1);
      start_col   <= COORD_BITS'(1);
      cur_line    <= COORD_BITS'(1);
      cur_col     <= COORD_BITS'(1);
      balance     <= 17'd0;
      open_depth  <= 16'd0;
      under_seen  <= 1'b0;
      under_line  <= COORD_BITS'(1);
      under_col   <= COORD_BITS'(1);
      outer_line  <= COORD_BITS'(1);
      outer_col   <= COORD_BITS'(1);
    end else if (advance) begin
      run_mode    <= run_mode_next;
      word_buffer <= word_buffer_next;
      word_count  <= word_count_next;
      num_acc     <= num_acc_next;
      num_sat     <= num_sat_next;
      start_line  <= start_line_next;
      start_col   <= start_col_next;
      cur_line    <= cur_line_next;
      cur_col     <= cur_col_next;
      balance     <= balance_next;
      open_depth  <= open_depth_next;
      under_seen  <= under_seen_next;
      under_line  <= under_line_next;
      under_col   <= under_col_next;
      outer_line  <= outer_line_next;
      outer_col   <= outer_col_next;
    end
  end

endmodule

@@ sv/tlex_out_seq.sv @@
// Result register that hands out the results of one byte, one beat at a time.
module tlex_out_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              bundle_load,
  input  tlex_pkg::bundle_t bundle,
  output logic              slot_free,
  output logic              tok_valid,
  input  logic              tok_stall,
  output tlex_pkg::result_t tok_beat
);

  logic [tlex_pkg::SLOTS-1:0]         mask;
  logic [tlex_pkg::SLOTS-1:0]         mask_after;
  logic [tlex_pkg::SLOTS-1:0]         pick;
  logic [tlex_pkg::SLOT_IDX_BITS-1:0] sel;
  tlex_pkg::result_t [tlex_pkg::SLOTS-1:0] slots;
  logic                               taken;

  // Lowest pending slot goes out first.
  always_comb begin
    pick = mask & (~mask + tlex_pkg::SLOTS'(1));
    sel  = '0;
    for (int i = 0; i < tlex_pkg::SLOTS; i++) begin
      if (pick[i]) begin
        sel = tlex_pkg::SLOT_IDX_BITS'(i);
      end
    end
    tok_valid  = |mask;
    taken      = tok_valid && !tok_stall;
    mask_after = taken ? (mask & ~pick) : mask;
    slot_free  = mask_after == '0;
    tok_beat   = slots[sel];
    tok_beat.last_result = (mask & ~pick) == '0;
  end

  // Pending mask and stored results.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (bundle_load) begin
      mask <= bundle.mask;
    end else begin
      mask <= mask_after;
    end
    if (bundle_load) begin
      slots <= bundle.slot;
    end
  end

endmodule
